[hw/rtl/vector_transform_alu_macros.svh]
// Assertion macros shared by the vector transform ALU RTL.
`ifndef VECTOR_TRANSFORM_ALU_MACROS_SVH
`define VECTOR_TRANSFORM_ALU_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define VTA_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define VTA_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/vta_pkg.sv]
// Package with request/result types, command codes and saturation helper.
package vta_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COMP_WIDTH_DEF = 32;
    localparam int ACC_W          = 68;
    localparam int SQRT_STEPS     = 32;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_SCALE = 4'd2;
    localparam logic [3:0] CMD_DIV   = 4'd3;
    localparam logic [3:0] CMD_DOT   = 4'd4;
    localparam logic [3:0] CMD_CROSS = 4'd5;
    localparam logic [3:0] CMD_MAG   = 4'd6;
    localparam logic [3:0] CMD_NORM  = 4'd7;
    localparam logic [3:0] CMD_XFORM = 4'd8;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] aw;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] bw;
        logic signed [31:0] scalar_in;
    } vta_in_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] rw;
        logic signed [31:0] scalar_out;
        logic               div_zero;
        logic               saturated;
    } vta_out_t;

    // Per-request state carried down the pipeline.
    typedef struct packed {
        logic [3:0]       cmd;
        logic [3:0][31:0] r;
        logic [31:0]      sc;
        logic             dz;
        logic             sat;
        logic [2:0][31:0] amag;
        logic [2:0]       qneg;
        logic [32:0]      den;
    } vta_ctx_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } vta_sat_t;

    // Clamp to a signed cw-bit range, return the 32-bit sign-extended pattern.
    function automatic vta_sat_t sat_clamp(input logic signed [ACC_W-1:0] v, input int cw);
        logic signed [ACC_W-1:0] maxv;
        logic signed [ACC_W-1:0] minv;
        vta_sat_t                res;
        maxv = signed'((ACC_W'(1) << (cw - 1)) - ACC_W'(1));
        minv = -maxv - ACC_W'(1);
        if (v > maxv)
        begin
            res.val = maxv[31:0];
            res.sat = 1'b1;
        end
        else if (v < minv)
        begin
            res.val = minv[31:0];
            res.sat = 1'b1;
        end
        else
        begin
            res.val = v[31:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

endpackage

[hw/rtl/vector_transform_alu.sv]
// A request passes three multiply/sum/round stages, 32 square-root stages,
// 32 + FRAC_BITS divider stages (FRAC_BITS is 16 at Q16.16) and the output
// register. Throughput: one request per cycle; the whole pipeline advances
// together and holds while a result waits on out_ready.
// Reset clears all valid bits and loads the identity matrix; no clearing pass.
`include "vector_transform_alu_macros.svh"

module vector_transform_alu #(
    parameter int FRAC_BITS  = vta_pkg::FRAC_BITS_DEF,
    parameter int COMP_WIDTH = vta_pkg::COMP_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vta_pkg::vta_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vta_pkg::vta_out_t out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_wdata
);
    import vta_pkg::*;

    localparam int          DIV_STEPS = 32 + FRAC_BITS;
    localparam logic [31:0] ONE       = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] SAT_MAX   = 32'((64'd1 << (COMP_WIDTH - 1)) - 64'd1);
    localparam logic [31:0] SAT_MIN   = ~SAT_MAX;

    logic en;

    // matrix registers: entry 2*row + k holds columns 2k (low) and 2k+1 (high)
    logic [7:0][63:0]  mat_reg;
    logic [15:0][31:0] mat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= {32'd0, ONE};
            mat_reg[1] <= '0;
            mat_reg[2] <= {ONE, 32'd0};
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= {32'd0, ONE};
            mat_reg[6] <= '0;
            mat_reg[7] <= {ONE, 32'd0};
        end
        else if (cfg_we)
            mat_reg[cfg_index] <= cfg_wdata;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_row
        for (genvar j = 0; j < 4; j++)
        begin : g_col
            assign mat[4*i+j] = mat_reg[2*i + j/2][(j%2)*32 +: 32];
        end
    end

    // front end
    logic        mac_valid;
    vta_ctx_t    mac_ctx;
    logic [63:0] mac_n;
    logic        mac_big;

    vta_mac #(
        .FRAC_BITS  (FRAC_BITS),
        .COMP_WIDTH (COMP_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .mat       (mat),
        .out_valid (mac_valid),
        .out_ctx   (mac_ctx),
        .sq_n      (mac_n),
        .sq_big    (mac_big)
    );

    logic        sq_valid;
    vta_ctx_t    sq_ctx;
    logic [32:0] sq_root;

    vta_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mac_valid),
        .in_ctx    (mac_ctx),
        .in_n      (mac_n),
        .in_big    (mac_big),
        .out_valid (sq_valid),
        .out_ctx   (sq_ctx),
        .out_root  (sq_root)
    );

    // magnitude result and normalize divisor
    vta_sat_t mag_sat;
    vta_ctx_t fix_ctx;

    always_comb
    begin
        mag_sat = sat_clamp(ACC_W'(sq_root), COMP_WIDTH);
        fix_ctx = sq_ctx;
        case (sq_ctx.cmd)
            CMD_MAG:
            begin
                fix_ctx.sc  = mag_sat.val;
                fix_ctx.sat = mag_sat.sat;
            end
            CMD_NORM:
            begin
                if (sq_root == '0)
                    fix_ctx.dz = 1'b1;
                else
                begin
                    fix_ctx.sc  = mag_sat.val;
                    fix_ctx.sat = mag_sat.sat;
                    fix_ctx.den = sq_root;
                end
            end
            default:
            begin
            end
        endcase
    end

    logic                      dv_valid;
    vta_ctx_t                  dv_ctx;
    logic [2:0][DIV_STEPS-1:0] dv_q;

    vta_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_ctx    (fix_ctx),
        .out_valid (dv_valid),
        .out_ctx   (dv_ctx),
        .out_q     (dv_q)
    );

    // apply quotient signs, saturate, assemble result
    vta_sat_t q_sat [3];
    vta_out_t res_next;
    vta_out_t out_data_reg;
    logic     out_valid_reg;

    always_comb
    begin
        logic signed [ACC_W-1:0] qv;
        logic                    sat_any;
        sat_any = dv_ctx.sat;
        for (int l = 0; l < 3; l++)
        begin
            qv       = signed'(ACC_W'(dv_q[l]));
            q_sat[l] = sat_clamp(dv_ctx.qneg[l] ? -qv : qv, COMP_WIDTH);
        end
        res_next.rx = dv_ctx.r[0];
        res_next.ry = dv_ctx.r[1];
        res_next.rz = dv_ctx.r[2];
        res_next.rw = dv_ctx.r[3];
        if ((dv_ctx.cmd == CMD_DIV || dv_ctx.cmd == CMD_NORM) && !dv_ctx.dz)
        begin
            res_next.rx = q_sat[0].val;
            res_next.ry = q_sat[1].val;
            res_next.rz = q_sat[2].val;
            sat_any     = sat_any | q_sat[0].sat | q_sat[1].sat | q_sat[2].sat;
        end
        res_next.scalar_out = dv_ctx.sc;
        res_next.div_zero   = dv_ctx.dz;
        res_next.saturated  = sat_any;
    end

    assign en = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= res_next;
    end

    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `VTA_ASSERT_IMPL(a_dz_zero, out_valid && out_data.div_zero, out_data.rx == '0 && out_data.ry == '0 && out_data.rz == '0 && out_data.rw == '0 && out_data.scalar_out == '0 && !out_data.saturated, "div_zero result not cleared")
    `VTA_ASSERT_IMPL(a_sat_clamped, out_valid && out_data.saturated, out_data.rx == SAT_MAX || out_data.rx == SAT_MIN || out_data.ry == SAT_MAX || out_data.ry == SAT_MIN || out_data.rz == SAT_MAX || out_data.rz == SAT_MIN || out_data.rw == SAT_MAX || out_data.rw == SAT_MIN || out_data.scalar_out == SAT_MAX || out_data.scalar_out == SAT_MIN, "saturated flag without clamped value")
    `VTA_ASSERT_IMPL(a_rw_xform_only, out_valid && out_data.rw != '0, !out_data.div_zero && out_data.scalar_out == '0, "nonzero rw outside transform")
    `VTA_ASSERT_NEXT(a_stall_hold, !in_ready, $stable(out_data) && out_valid, "pipeline moved during stall")

endmodule

[hw/rtl/vta_mac.sv]
// Multiply, sum and round/saturate front end: three register stages.
module vta_mac #(
    parameter int FRAC_BITS  = vta_pkg::FRAC_BITS_DEF,
    parameter int COMP_WIDTH = vta_pkg::COMP_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  vta_pkg::vta_in_t  in_data,
    input  logic [15:0][31:0] mat,
    output logic              out_valid,
    output vta_pkg::vta_ctx_t out_ctx,
    output logic [63:0]       sq_n,
    output logic              sq_big
);
    import vta_pkg::*;

    // stage 1: operand select and products
    logic signed [31:0] a0 [4];
    logic signed [31:0] b0 [4];
    logic signed [31:0] mx [16];
    logic signed [31:0] my [16];
    logic signed [63:0] prod_reg [16];
    vta_in_t            in1_reg;
    logic               v1_reg;

    assign a0[0] = in_data.ax;
    assign a0[1] = in_data.ay;
    assign a0[2] = in_data.az;
    assign a0[3] = in_data.aw;
    assign b0[0] = in_data.bx;
    assign b0[1] = in_data.by;
    assign b0[2] = in_data.bz;
    assign b0[3] = in_data.bw;

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            mx[k] = '0;
            my[k] = '0;
        end
        case (in_data.cmd) inside
            CMD_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mx[i] = a0[i];
                    my[i] = in_data.scalar_in;
                end
            end
            CMD_DOT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mx[i] = a0[i];
                    my[i] = b0[i];
                end
            end
            CMD_MAG, CMD_NORM:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mx[i] = a0[i];
                    my[i] = a0[i];
                end
            end
            CMD_CROSS:
            begin
                mx[0] = a0[1]; my[0] = b0[2];
                mx[1] = a0[2]; my[1] = b0[1];
                mx[2] = a0[2]; my[2] = b0[0];
                mx[3] = a0[0]; my[3] = b0[2];
                mx[4] = a0[0]; my[4] = b0[1];
                mx[5] = a0[1]; my[5] = b0[0];
            end
            CMD_XFORM:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        mx[4*j+i] = a0[i];
                        my[4*j+i] = signed'(mat[4*i+j]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in1_reg <= in_data;
            for (int k = 0; k < 16; k++)
                prod_reg[k] <= 64'(mx[k]) * 64'(my[k]);
        end
    end

    // stage 2: sums
    logic signed [31:0]      a1 [4];
    logic signed [31:0]      b1 [4];
    logic signed [ACC_W-1:0] p1 [16];
    logic signed [ACC_W-1:0] acc_next [4];
    logic signed [ACC_W-1:0] acc_reg [4];
    vta_in_t                 in2_reg;
    logic                    v2_reg;

    assign a1[0] = in1_reg.ax;
    assign a1[1] = in1_reg.ay;
    assign a1[2] = in1_reg.az;
    assign a1[3] = in1_reg.aw;
    assign b1[0] = in1_reg.bx;
    assign b1[1] = in1_reg.by;
    assign b1[2] = in1_reg.bz;
    assign b1[3] = in1_reg.bw;

    always_comb
    begin
        for (int k = 0; k < 16; k++)
            p1[k] = ACC_W'(prod_reg[k]);
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            acc_next[j] = '0;
        case (in1_reg.cmd) inside
            CMD_ADD:
            begin
                for (int i = 0; i < 3; i++)
                    acc_next[i] = ACC_W'(a1[i]) + ACC_W'(b1[i]);
            end
            CMD_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    acc_next[i] = ACC_W'(a1[i]) - ACC_W'(b1[i]);
            end
            CMD_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    acc_next[i] = p1[i];
            end
            CMD_DOT, CMD_MAG, CMD_NORM:
                acc_next[0] = p1[0] + p1[1] + p1[2] + p1[3];
            CMD_CROSS:
            begin
                acc_next[0] = p1[0] - p1[1];
                acc_next[1] = p1[2] - p1[3];
                acc_next[2] = p1[4] - p1[5];
            end
            CMD_XFORM:
            begin
                for (int j = 0; j < 4; j++)
                    acc_next[j] = p1[4*j] + p1[4*j+1] + p1[4*j+2] + p1[4*j+3];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in2_reg <= in1_reg;
            for (int j = 0; j < 4; j++)
                acc_reg[j] <= acc_next[j];
        end
    end

    // stage 3: round, saturate, set up divide operands
    localparam logic signed [ACC_W-1:0] HALF = signed'(ACC_W'(1) << (FRAC_BITS - 1));

    logic signed [31:0]      a2 [4];
    logic signed [ACC_W-1:0] rnd [4];
    vta_sat_t                sr_raw [4];
    vta_sat_t                sr_rnd [4];
    vta_ctx_t                ctx_next;
    vta_ctx_t                ctx_reg;
    logic [63:0]             n_reg;
    logic                    big_reg;
    logic                    v3_reg;

    assign a2[0] = in2_reg.ax;
    assign a2[1] = in2_reg.ay;
    assign a2[2] = in2_reg.az;
    assign a2[3] = in2_reg.aw;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rnd[j]    = (acc_reg[j] + HALF) >>> FRAC_BITS;
            sr_raw[j] = sat_clamp(acc_reg[j], COMP_WIDTH);
            sr_rnd[j] = sat_clamp(rnd[j], COMP_WIDTH);
        end
    end

    always_comb
    begin
        ctx_next     = '0;
        ctx_next.cmd = in2_reg.cmd;
        for (int i = 0; i < 3; i++)
            ctx_next.amag[i] = a2[i][31] ? 32'(-a2[i]) : a2[i];
        case (in2_reg.cmd) inside
            CMD_ADD, CMD_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    ctx_next.r[i] = sr_raw[i].val;
                ctx_next.sat = sr_raw[0].sat | sr_raw[1].sat | sr_raw[2].sat;
            end
            CMD_SCALE, CMD_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                    ctx_next.r[i] = sr_rnd[i].val;
                ctx_next.sat = sr_rnd[0].sat | sr_rnd[1].sat | sr_rnd[2].sat;
            end
            CMD_DOT:
            begin
                ctx_next.sc  = sr_rnd[0].val;
                ctx_next.sat = sr_rnd[0].sat;
            end
            CMD_XFORM:
            begin
                for (int i = 0; i < 4; i++)
                    ctx_next.r[i] = sr_rnd[i].val;
                ctx_next.sat = sr_rnd[0].sat | sr_rnd[1].sat | sr_rnd[2].sat | sr_rnd[3].sat;
            end
            CMD_DIV:
            begin
                if (in2_reg.scalar_in == '0)
                    ctx_next.dz = 1'b1;
                else
                begin
                    ctx_next.den = {1'b0, in2_reg.scalar_in[31] ? 32'(-in2_reg.scalar_in)
                                                                : in2_reg.scalar_in};
                    for (int i = 0; i < 3; i++)
                        ctx_next.qneg[i] = a2[i][31] ^ in2_reg.scalar_in[31];
                end
            end
            CMD_NORM:
            begin
                for (int i = 0; i < 3; i++)
                    ctx_next.qneg[i] = a2[i][31];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx_next;
            n_reg   <= acc_reg[0][63:0];
            big_reg <= acc_reg[0][64];
        end
    end

    assign out_valid = v3_reg;
    assign out_ctx   = ctx_reg;
    assign sq_n      = n_reg;
    assign sq_big    = big_reg;

endmodule

[hw/rtl/vta_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module vta_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  vta_pkg::vta_ctx_t in_ctx,
    input  logic [63:0]       in_n,
    input  logic              in_big,
    output logic              out_valid,
    output vta_pkg::vta_ctx_t out_ctx,
    output logic [32:0]       out_root
);
    import vta_pkg::*;

    logic        v_reg    [SQRT_STEPS];
    vta_ctx_t    ctx_reg  [SQRT_STEPS];
    logic [63:0] n_reg    [SQRT_STEPS];
    logic [33:0] rem_reg  [SQRT_STEPS];
    logic [31:0] root_reg [SQRT_STEPS];
    logic        big_reg  [SQRT_STEPS];

    logic [63:0] n_next    [SQRT_STEPS];
    logic [33:0] rem_next  [SQRT_STEPS];
    logic [31:0] root_next [SQRT_STEPS];

    always_comb
    begin
        logic [63:0] n_p;
        logic [33:0] rem_p;
        logic [31:0] root_p;
        logic [35:0] trial;
        logic [35:0] sub;
        logic        ge;
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            if (s == 0)
            begin
                n_p    = in_n;
                rem_p  = '0;
                root_p = '0;
            end
            else
            begin
                n_p    = n_reg[s-1];
                rem_p  = rem_reg[s-1];
                root_p = root_reg[s-1];
            end
            // bring down the next two bits and try root*4+1
            trial        = {rem_p, n_p[63:62]};
            sub          = {2'b00, root_p, 2'b01};
            ge           = trial >= sub;
            rem_next[s]  = ge ? 34'(trial - sub) : trial[33:0];
            root_next[s] = {root_p[30:0], ge};
            n_next[s]    = {n_p[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQRT_STEPS; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < SQRT_STEPS; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            big_reg[0] <= in_big;
            for (int s = 1; s < SQRT_STEPS; s++)
            begin
                ctx_reg[s] <= ctx_reg[s-1];
                big_reg[s] <= big_reg[s-1];
            end
            for (int s = 0; s < SQRT_STEPS; s++)
            begin
                n_reg[s]    <= n_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_ctx   = ctx_reg[SQRT_STEPS-1];
    // a sum of exactly 2^64 has root 2^32
    assign out_root  = big_reg[SQRT_STEPS-1] ? {1'b1, 32'd0} : {1'b0, root_reg[SQRT_STEPS-1]};

endmodule

[hw/rtl/vta_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor.
module vta_div #(
    parameter int FRAC_BITS = vta_pkg::FRAC_BITS_DEF,
    localparam int STEPS    = 32 + FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  vta_pkg::vta_ctx_t     in_ctx,
    output logic                  out_valid,
    output vta_pkg::vta_ctx_t     out_ctx,
    output logic [2:0][STEPS-1:0] out_q
);
    import vta_pkg::*;

    logic                  v_reg   [STEPS];
    vta_ctx_t              ctx_reg [STEPS];
    logic [2:0][32:0]      rem_reg [STEPS];
    logic [2:0][STEPS-1:0] nq_reg  [STEPS];

    logic [2:0][32:0]      rem_next [STEPS];
    logic [2:0][STEPS-1:0] nq_next  [STEPS];

    always_comb
    begin
        logic [32:0]      den;
        logic [32:0]      rem_p;
        logic [STEPS-1:0] nq_p;
        logic [33:0]      trial;
        logic             ge;
        for (int s = 0; s < STEPS; s++)
        begin
            den = (s == 0) ? in_ctx.den : ctx_reg[s-1].den;
            for (int l = 0; l < 3; l++)
            begin
                if (s == 0)
                begin
                    rem_p = '0;
                    nq_p  = STEPS'(in_ctx.amag[l]) << FRAC_BITS;
                end
                else
                begin
                    rem_p = rem_reg[s-1][l];
                    nq_p  = nq_reg[s-1][l];
                end
                // shift in a dividend bit, shift out a quotient bit
                trial          = {rem_p, nq_p[STEPS-1]};
                ge             = trial >= {1'b0, den};
                rem_next[s][l] = ge ? 33'(trial - {1'b0, den}) : trial[32:0];
                nq_next[s][l]  = {nq_p[STEPS-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STEPS; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < STEPS; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int s = 1; s < STEPS; s++)
                ctx_reg[s] <= ctx_reg[s-1];
            for (int s = 0; s < STEPS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                nq_reg[s]  <= nq_next[s];
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_ctx   = ctx_reg[STEPS-1];
    assign out_q     = nq_reg[STEPS-1];

endmodule
